// ----- hdl/pctd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_pkg
// Types, character constants and helpers shared by the percent decoder.
// ----------------------------------------------------------------------------
package pctd_pkg;

    // special characters
    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // most result bytes one input transaction can cause
    localparam int MAX_RESULTS = 3;

    // default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // input transaction
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    // output transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       stream_end;
    } out_t;

    // result bytes caused by one input transaction
    typedef struct packed {
        logic [1:0]                   cnt;
        logic                         last;
        logic [MAX_RESULTS-1:0][7:0]  data;
    } job_t;

    // hex digit value in the low nibble, bit 4 set when not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b0, 4'(b - 8'h30)};
        if (b >= 8'h41 && b <= 8'h46) r = {1'b0, 4'(b - 8'h41 + 8'd10)};
        if (b >= 8'h61 && b <= 8'h66) r = {1'b0, 4'(b - 8'h61 + 8'd10)};
        return r;
    endfunction

endpackage

// ----- hdl/pctd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_front
// Tracks the escape state and turns each input byte into a job of result bytes.
// ----------------------------------------------------------------------------
module pctd_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  pctd_pkg::in_t   in_data,
    output pctd_pkg::job_t  job,
    output logic            push
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PCT,
        PH_DIGIT
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic       idle_go;
    logic [4:0] nib_b;
    logic [4:0] nib_h;

    // classify the byte against the pending escape
    always_comb
    begin
        nib_b      = pctd_pkg::hex_nibble(in_data.in_byte);
        nib_h      = pctd_pkg::hex_nibble(held_reg);
        job        = '0;
        job.last   = in_data.in_last;
        phase_next = PH_IDLE;
        held_next  = held_reg;
        idle_go    = 1'b0;
        case (phase_reg)
            PH_PCT:
            begin
                if (!nib_b[4])
                begin
                    if (in_data.in_last)
                    begin
                        job.data[0] = pctd_pkg::PCT_CHAR;
                        job.data[1] = in_data.in_byte;
                        job.cnt     = 2'd2;
                    end
                    else
                    begin
                        phase_next = PH_DIGIT;
                        held_next  = in_data.in_byte;
                    end
                end
                else
                begin
                    job.data[0] = pctd_pkg::PCT_CHAR;
                    job.cnt     = 2'd1;
                    idle_go     = 1'b1;
                end
            end
            PH_DIGIT:
            begin
                if (!nib_b[4] && !nib_h[4])
                begin
                    job.data[0] = {nib_h[3:0], nib_b[3:0]};
                    job.cnt     = 2'd1;
                end
                else
                begin
                    job.data[0] = pctd_pkg::PCT_CHAR;
                    job.data[1] = held_reg;
                    job.cnt     = 2'd2;
                    idle_go     = 1'b1;
                end
            end
            default:
            begin
                idle_go = 1'b1;
            end
        endcase

        // byte handled with no escape pending
        if (idle_go)
        begin
            if (in_data.in_byte == pctd_pkg::PCT_CHAR)
            begin
                if (in_data.in_last)
                begin
                    job.data[job.cnt] = pctd_pkg::PCT_CHAR;
                    job.cnt           = job.cnt + 2'd1;
                end
                else
                begin
                    phase_next = PH_PCT;
                end
            end
            else
            begin
                job.data[job.cnt] = (in_data.in_byte == pctd_pkg::PLUS_CHAR) ?
                                    pctd_pkg::SPACE_CHAR : in_data.in_byte;
                job.cnt           = job.cnt + 2'd1;
            end
        end

        // stream end returns to reset state
        if (in_data.in_last)
        begin
            phase_next = PH_IDLE;
            held_next  = 8'h00;
        end

        push = accept && (job.cnt != 2'd0);
    end

    // escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ----- hdl/pctd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_queue
// Short job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module pctd_queue
#(
    parameter int DEPTH = pctd_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pctd_pkg::job_t  push_job,
    input  logic            pop,
    output pctd_pkg::job_t  head,
    output logic            nonempty,
    output logic            full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pctd_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    // status
    assign nonempty = (count_reg != '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign head     = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/pctd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_back
// Emits the bytes of the head job one per cycle, unless out_stall holds them, through an output register.
// ----------------------------------------------------------------------------
module pctd_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  pctd_pkg::job_t  head,
    input  logic            head_valid,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output pctd_pkg::out_t  out_data
);

    logic           out_valid_reg;
    pctd_pkg::out_t out_reg;
    logic [1:0]     idx_reg;
    logic           load;
    logic           final_byte;

    // select the next result byte
    always_comb
    begin
        load       = head_valid && (!out_valid_reg || !out_stall);
        final_byte = (idx_reg == head.cnt - 2'd1);
        pop        = load && final_byte;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= final_byte ? 2'd0 : idx_reg + 2'd1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.out_byte   <= head.data[idx_reg];
            out_reg.run_end    <= final_byte;
            out_reg.stream_end <= final_byte && head.last;
        end
    end

endmodule

// ----- hdl/percent_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_decoder
// Streaming URL percent and plus decoder for one form-urlencoded component.
// ----------------------------------------------------------------------------
// Input: one input transaction per cycle while the job queue is not full
//   (in_stall); the back emits one result byte per cycle unless out_stall
//   holds it, so an input causing 2 or 3 results keeps its job in the queue
//   until its last result byte is loaded.
// Reset: rst_n asynchronous, clears escape state, queue and output valid.
// ----------------------------------------------------------------------------
module percent_decoder
#(
    parameter int QUEUE_DEPTH = pctd_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  pctd_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output pctd_pkg::out_t  out_data
);

    pctd_pkg::job_t job;
    pctd_pkg::job_t head;
    logic           push;
    logic           pop;
    logic           nonempty;
    logic           full;
    logic           accept;

    // input handshake
    assign in_stall = full;
    assign accept   = in_valid && !full;

    // classification and escape state
    pctd_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_data (in_data),
        .job     (job),
        .push    (push)
    );

    // job queue
    pctd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .head     (head),
        .nonempty (nonempty),
        .full     (full)
    );

    // result serializer
    pctd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (nonempty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

// ----- hdl/pctd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_checker
// Port level checks on the percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pctd_checker
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            out_valid,
    input  logic            out_stall,
    input  pctd_pkg::out_t  out_data
);

    // no result transaction offered once reset has been seen
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high during reset");

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // a stalled result keeps its payload
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("out_data changed while stalled");

    // the final byte of a stream also closes its run
    a_stream_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.stream_end |-> out_data.run_end)
        else $error("stream_end without run_end");

endmodule

bind percent_decoder pctd_checker u_pctd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the percent decoder. Directed streams cover plain
// bytes, plus signs, valid escapes in both letter cases, broken escapes and
// flushes at stream end. Random streams of plain bytes, plus signs, good and
// broken escapes follow. A local decoder predicts every output transaction,
// each checked field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    // escape progress of the local decoder
    typedef enum logic [1:0] {ESC_IDLE, ESC_PCT, ESC_DIGIT} esc_phase_t;

    logic           clk;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_stall;
    pctd_pkg::in_t  in_data   = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    pctd_pkg::out_t out_data;

    // local decoder state and expected output transactions
    esc_phase_t     esc_phase = ESC_IDLE;
    logic [7:0]     held_digit = 8'h00;
    logic [7:0]     run_bytes[$];
    pctd_pkg::out_t expected_q[$];
    pctd_pkg::out_t exp_res;

    int  items_sent     = 0;
    int  streams_sent   = 0;
    int  results_seen   = 0;
    int  fail_cnt       = 0;
    bit  gaps_on        = 1'b1;
    int  stall_left     = 0;
    int  free_left      = 0;

    percent_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #600000;
        $display("simulation failed");
        $finish;
    end

    // hex digit helpers
    function automatic bit is_hex(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
    endfunction

    function automatic logic [3:0] digit_val(input logic [7:0] b);
        if (b <= "9")
            return b[3:0];
        return b[3:0] + 4'd9;
    endfunction

    // appends one predicted byte to the current run
    task automatic add_run_byte(input logic [7:0] b);
        run_bytes = {run_bytes, b};
    endtask

    // byte handled with no escape pending
    task automatic decode_plain(input logic [7:0] b, input logic last);
        if (b == pctd_pkg::PCT_CHAR)
        begin
            if (last)
                add_run_byte(pctd_pkg::PCT_CHAR);
            else
                esc_phase = ESC_PCT;
        end
        else if (b == pctd_pkg::PLUS_CHAR)
            add_run_byte(pctd_pkg::SPACE_CHAR);
        else
            add_run_byte(b);
    endtask

    // predicts the output transactions caused by one accepted byte
    task automatic decode_byte(input logic [7:0] b, input logic last);
        esc_phase_t     phase;
        pctd_pkg::out_t res;
        phase = esc_phase;
        esc_phase = ESC_IDLE;
        run_bytes.delete();
        case (phase)
            ESC_PCT:
            begin
                if (is_hex(b))
                begin
                    if (last)
                    begin
                        add_run_byte(pctd_pkg::PCT_CHAR);
                        add_run_byte(b);
                    end
                    else
                    begin
                        esc_phase = ESC_DIGIT;
                        held_digit = b;
                    end
                end
                else
                begin
                    add_run_byte(pctd_pkg::PCT_CHAR);
                    decode_plain(b, last);
                end
            end
            ESC_DIGIT:
            begin
                if (is_hex(b) && is_hex(held_digit))
                    add_run_byte({digit_val(held_digit), digit_val(b)});
                else
                begin
                    add_run_byte(pctd_pkg::PCT_CHAR);
                    add_run_byte(held_digit);
                    decode_plain(b, last);
                end
            end
            default:
                decode_plain(b, last);
        endcase
        if (last)
        begin
            esc_phase = ESC_IDLE;
            held_digit = 8'h00;
        end
        foreach (run_bytes[i])
        begin
            res.out_byte   = run_bytes[i];
            res.run_end    = (i == run_bytes.size() - 1);
            res.stream_end = last && (i == run_bytes.size() - 1);
            expected_q = {expected_q, res};
        end
    endtask

    // random gap before a transaction: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // sends one byte and predicts its results once accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= '{in_byte: b, in_last: last};
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        decode_byte(b, last);
        items_sent++;
        if (last)
            streams_sent++;
    endtask

    task automatic send_text(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // holds the sender until every expected transaction has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // random byte helpers
    function automatic logic [7:0] rand_hex_digit();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return 8'("0" + v);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0: return pctd_pkg::PCT_CHAR;
            1: return pctd_pkg::PLUS_CHAR;
            default:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (is_hex(b));
                return b;
            end
        endcase
    endfunction

    // plain bytes at both extremes and plus to space
    task automatic test_plain_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(pctd_pkg::PLUS_CHAR, 1'b0);
        send_byte("z", 1'b1);
    endtask

    // valid escapes with digits only and in mixed case, last on the second digit
    task automatic test_valid_escapes();
        send_text("%41%fF", 1'b0);
        send_text("%09", 1'b1);
    endtask

    // broken escapes: bad first digit, bad second digit then a new percent
    task automatic test_broken_escapes();
        send_text("%G%4%Q", 1'b0);
    endtask

    // flush at stream end: lone percent, held digit, percent then plus
    task automatic test_stream_end();
        send_text("%", 1'b1);
        send_text("%c", 1'b1);
        send_text("%+", 1'b1);
    endtask

    // random streams of plain bytes, plus signs, well-formed and broken escapes
    task automatic test_random_streams();
        logic [7:0] stream_q[$];
        int         target;
        int         parts;
        target = items_sent + 96;
        while (items_sent < target)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            stream_q.delete();
            parts = $urandom_range(1, 6);
            repeat (parts)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: stream_q = {stream_q, 8'($urandom_range(0, 255))};
                    3:       stream_q = {stream_q, pctd_pkg::PLUS_CHAR};
                    4, 5, 6:
                    begin
                        stream_q = {stream_q, pctd_pkg::PCT_CHAR};
                        stream_q = {stream_q, rand_hex_digit()};
                        stream_q = {stream_q, rand_hex_digit()};
                    end
                    7:
                    begin
                        stream_q = {stream_q, pctd_pkg::PCT_CHAR};
                        stream_q = {stream_q, rand_non_hex()};
                    end
                    8:
                    begin
                        stream_q = {stream_q, pctd_pkg::PCT_CHAR};
                        stream_q = {stream_q, rand_hex_digit()};
                        stream_q = {stream_q, rand_non_hex()};
                    end
                    default: stream_q = {stream_q, pctd_pkg::PCT_CHAR};
                endcase
            end
            foreach (stream_q[i])
                send_byte(stream_q[i], i == stream_q.size() - 1);
            if ($urandom_range(0, 14) == 0)
                wait_idle();
        end
        gaps_on = 1'b1;
    endtask

    // output stall: short bursts, occasional long holds, short or occasional long free stretches
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (free_left > 0)
        begin
            out_stall <= 1'b0;
            free_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: stall_left = $urandom_range(1, 3);
                6:                stall_left = $urandom_range(10, 40);
                default:          stall_left = 0;
            endcase
            free_left = ($urandom_range(0, 9) < 2) ? $urandom_range(30, 80)
                                                   : $urandom_range(0, 5);
        end
    end

    // result check against the oldest expected transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected transaction: out_byte %h", out_data.out_byte);
                fail_cnt++;
            end
            else
            begin
                exp_res = expected_q.pop_front();
                if (out_data.out_byte !== exp_res.out_byte)
                begin
                    $error("out_byte mismatch: expected %h, actual %h",
                           exp_res.out_byte, out_data.out_byte);
                    fail_cnt++;
                end
                if (out_data.run_end !== exp_res.run_end)
                begin
                    $error("run_end mismatch: expected %b, actual %b",
                           exp_res.run_end, out_data.run_end);
                    fail_cnt++;
                end
                if (out_data.stream_end !== exp_res.stream_end)
                begin
                    $error("stream_end mismatch: expected %b, actual %b",
                           exp_res.stream_end, out_data.stream_end);
                    fail_cnt++;
                end
            end
        end
    end

    // test sequence
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_bytes();
        test_valid_escapes();
        test_broken_escapes();
        test_stream_end();
        wait_idle();
        test_random_streams();
        wait_idle();
        repeat (8) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            $error("%0d expected transactions never came out", expected_q.size());
            fail_cnt++;
        end
        $display("covered %0d input bytes in %0d streams, %0d decoded bytes checked",
                 items_sent, streams_sent, results_seen);
        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
